// ===== rtl/gtkcs_pkg.sv =====
// shared constants for the grouped top-k camera select block
package gtkcs_pkg;

  localparam int DEF_MAX_CAMS    = 16;  // score store depth
  localparam int RESULT_LIMIT    = 16;  // most selections per set
  localparam int GROUP_COUNT     = 4;   // fixed groups taken first
  localparam int GROUP_SIZE      = 3;   // cameras per group
  localparam int GROUPED_MIN     = 12;  // cameras needed for the group pass
  localparam int SCORE_W         = 16;
  localparam int LIMIT_W         = 5;
  localparam int INDEX_OUT_W     = 4;
  localparam int MAX_COUNT_RESET = 4;

endpackage

// ===== rtl/gtkcs_ram.sv =====
// generic simple dual-port ram with registered read
module gtkcs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/grouped_top_k_camera_select.sv =====
// top level of the grouped top-k camera select block
//
// Cameras stream in one score per item (tlast closes the set); each item is
// written to a score ram. After the closing item the block drops ready and
// works out the selection with one shared compare unit that scans the ram
// one entry per cycle: a decision state, then one pass per selected camera.
// In the grouped case (12 or more cameras, max_count of 4 or more) the first
// four passes cover three cameras each, every other pass covers all n loaded
// cameras. When the set fits within max_count no scan runs. Emission then
// walks the selection mask in ascending order one camera per cycle, holding
// on a chosen camera while the output is stalled; one result item per chosen
// camera, tlast on the final one. A max_count of 0 gives one item with tuser
// low. Only cameras up to MAX_CAMS are stored; extra scores of a set are
// dropped. The output register lets the next set start loading while the
// last result still waits.
module grouped_top_k_camera_select
  import gtkcs_pkg::*;
#(
  parameter int MAX_CAMS = DEF_MAX_CAMS
) (
  input  logic         clk,
  input  logic         rst,
  // configuration: max_count
  input  logic         cfg_we,
  input  logic [4:0]   cfg_wdata,
  // input items
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [15:0]  s_axis_tdata,   // [15:0] score
  input  logic         s_axis_tlast,   // last camera of the set
  // result items
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [7:0]   m_axis_tdata,   // [3:0] cam_index, [7:4] zero
  output logic         m_axis_tuser,   // [0] valid_res
  output logic         m_axis_tlast    // end_of_run
);

  localparam int IW = $clog2(MAX_CAMS);       // ram index width
  localparam int CW = $clog2(MAX_CAMS + 1);   // camera count width
  localparam int NW = (CW > LIMIT_W) ? CW : LIMIT_W;  // compare width

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_SETUP,
    ST_SCAN,
    ST_EMIT,
    ST_EMPTY
  } state_t;

  state_t                state;
  logic [LIMIT_W-1:0]    max_count;
  logic [CW-1:0]         count;        // cameras loaded in open set
  logic [CW-1:0]         n;            // cameras in closed set
  logic [LIMIT_W-1:0]    limit;
  logic [LIMIT_W-1:0]    total;        // selections to emit
  logic [LIMIT_W-1:0]    emitted;
  logic [LIMIT_W-1:0]    pick;         // selection pass number
  logic                  grouped;
  logic [MAX_CAMS-1:0]   selected_mask;

  // scan unit
  logic [IW-1:0]         rd_idx;
  logic [CW-1:0]         hi;
  logic                  issuing;
  logic                  cmp_v;
  logic                  cmp_last;
  logic [IW-1:0]         cmp_idx;
  logic                  best_v;
  logic [IW-1:0]         best_idx;
  logic [SCORE_W-1:0]    best_score;
  logic [SCORE_W-1:0]    rdata;

  // emission
  logic [CW-1:0]         eidx;

  // output register
  logic                  out_valid;
  logic [INDEX_OUT_W-1:0] out_index;
  logic                  out_vres;
  logic                  out_end;

  logic                  in_acc;
  logic                  room;
  logic [CW-1:0]         count_next;
  logic                  ram_we;
  logic [LIMIT_W-1:0]    lim;
  logic [NW-1:0]         n_ext;
  logic [NW-1:0]         lim_ext;
  logic [MAX_CAMS-1:0]   all_mask;
  logic [NW-1:0]         grp_lo;
  logic                  grp_pass;
  logic                  cand;
  logic [IW-1:0]         best_idx_next;
  logic                  slot_free;
  logic                  emit_end;

  assign s_axis_tready = (state == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign room          = (count < CW'(MAX_CAMS));
  assign count_next    = room ? count + CW'(1) : count;
  assign ram_we        = in_acc && room;

  // clamp max_count to the result limit
  assign lim     = (max_count > LIMIT_W'(RESULT_LIMIT)) ? LIMIT_W'(RESULT_LIMIT) : max_count;
  assign n_ext   = NW'(n);
  assign lim_ext = NW'(lim);

  always_comb begin
    for (int i = 0; i < MAX_CAMS; i++) begin
      all_mask[i] = (CW'(i) < n);
    end
  end

  // first index of group number pick: 3 * pick
  assign grp_lo   = (NW'(pick) << 1) + NW'(pick);
  assign grp_pass = grouped && (pick < LIMIT_W'(GROUP_COUNT));

  // compare stage: strict greater keeps the lower index on a tie
  assign cand = cmp_v && !selected_mask[cmp_idx] && (!best_v || (rdata > best_score));
  assign best_idx_next = cand ? cmp_idx : best_idx;

  assign slot_free = !out_valid || m_axis_tready;
  assign emit_end  = (emitted + LIMIT_W'(1)) == total;

  gtkcs_ram #(
    .WIDTH (SCORE_W),
    .DEPTH (MAX_CAMS)
  ) u_score_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count[IW-1:0]),
    .wdata (s_axis_tdata),
    .raddr (rd_idx),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      max_count     <= LIMIT_W'(MAX_COUNT_RESET);
      count         <= '0;
      selected_mask <= '0;
      out_valid     <= 1'b0;
      issuing       <= 1'b0;
      cmp_v         <= 1'b0;
      best_v        <= 1'b0;
    end else begin
      if (cfg_we) begin
        max_count <= cfg_wdata;
      end
      if (out_valid && m_axis_tready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (in_acc) begin
            count <= count_next;
            if (s_axis_tlast) begin
              n     <= count_next;
              count <= '0;
              state <= ST_DECIDE;
            end
          end
        end

        ST_DECIDE: begin
          limit   <= lim;
          pick    <= '0;
          grouped <= (n_ext >= NW'(GROUPED_MIN)) && (lim >= LIMIT_W'(GROUP_COUNT));
          eidx    <= '0;
          emitted <= '0;
          if (lim == '0) begin
            selected_mask <= '0;
            state         <= ST_EMPTY;
          end else if (n_ext <= lim_ext) begin
            // whole set fits: take every camera
            selected_mask <= all_mask;
            total         <= LIMIT_W'(n);
            state         <= ST_EMIT;
          end else begin
            selected_mask <= '0;
            total         <= lim;
            state         <= ST_SETUP;
          end
        end

        ST_SETUP: begin
          // group pass covers three cameras, fill pass the whole set
          if (grp_pass) begin
            rd_idx <= IW'(grp_lo);
            hi     <= CW'(grp_lo + NW'(GROUP_SIZE));
          end else begin
            rd_idx <= '0;
            hi     <= n;
          end
          issuing <= 1'b1;
          cmp_v   <= 1'b0;
          best_v  <= 1'b0;
          state   <= ST_SCAN;
        end

        ST_SCAN: begin
          if (issuing) begin
            cmp_v    <= 1'b1;
            cmp_idx  <= rd_idx;
            cmp_last <= (CW'(rd_idx) == hi - CW'(1));
            rd_idx   <= rd_idx + IW'(1);
            if (CW'(rd_idx) == hi - CW'(1)) begin
              issuing <= 1'b0;
            end
          end else begin
            cmp_v <= 1'b0;
          end
          if (cand) begin
            best_v     <= 1'b1;
            best_idx   <= cmp_idx;
            best_score <= rdata;
          end
          if (cmp_v && cmp_last) begin
            selected_mask[best_idx_next] <= 1'b1;
            cmp_v <= 1'b0;
            if (pick + LIMIT_W'(1) == limit) begin
              state <= ST_EMIT;
            end else begin
              pick  <= pick + LIMIT_W'(1);
              state <= ST_SETUP;
            end
          end
        end

        ST_EMIT: begin
          if (selected_mask[eidx[IW-1:0]]) begin
            if (slot_free) begin
              out_valid <= 1'b1;
              out_index <= eidx[INDEX_OUT_W-1:0];
              out_vres  <= 1'b1;
              out_end   <= emit_end;
              emitted   <= emitted + LIMIT_W'(1);
              eidx      <= eidx + CW'(1);
              if (emit_end) begin
                state <= ST_IDLE;
              end
            end
          end else begin
            eidx <= eidx + CW'(1);
          end
        end

        ST_EMPTY: begin
          // empty selection: one item with no camera
          if (slot_free) begin
            out_valid <= 1'b1;
            out_index <= '0;
            out_vres  <= 1'b0;
            out_end   <= 1'b1;
            state     <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {4'b0000, out_index};
  assign m_axis_tuser  = out_vres;
  assign m_axis_tlast  = out_end;

endmodule
